### rtl/core/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared types, constants and helpers of the timecode line parser.
// ----------------------------------------------------------------------------
package gtp_pkg;

	localparam int unsigned POS_W = 5;
	localparam logic [POS_W-1:0] DONE_POS = 5'd23;
	localparam logic [POS_W-1:0] SUM_LEN = 5'd21;
	localparam logic [POS_W-1:0] PCHK2 = 5'd22;
	localparam int unsigned NUM_ACC = 5;
	localparam int unsigned NUM_FLAG = 5;
	localparam int unsigned TDATA_W = 80;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_2 = 8'h32;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_4 = 8'h34;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [6:0] MONTH_JUN = 7'd6;
	localparam logic [6:0] MONTH_DEC = 7'd12;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NO_FORMAT = 3'd1,
		ST_NOT_T2 = 3'd2,
		ST_FEW_FIELDS = 3'd3,
		ST_CHECKSUM = 3'd4,
		ST_QUALITY = 3'd5,
		ST_BAD_LEAP = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		LEAP_NONE = 2'd0,
		LEAP_ADD = 2'd1,
		LEAP_DEL = 2'd2,
		LEAP_NOSYNC = 2'd3
	} leap_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic skipping;
		logic [13:0] year_acc;
		logic [NUM_ACC-1:0][6:0] acc;
		logic [NUM_FLAG-1:0][7:0] flags;
		logic [7:0] running_sum;
		logic [7:0] expected_sum;
		status_t error_code;
	} scan_t;

	typedef struct packed {
		status_t status;
		logic [13:0] year;
		logic [6:0] month;
		logic [6:0] day;
		logic [6:0] hour;
		logic [6:0] minute;
		logic [6:0] second;
		logic [7:0] time_quality;
		logic [7:0] freq_quality;
		leap_t leap_state;
		logic [7:0] service_request;
	} result_t;

	// Returns the hex digit value in the low four bits and a valid flag on top.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

### rtl/core/gtp_scan.sv
// ----------------------------------------------------------------------------
// gtp_scan
// Per-byte scanner state: next-state logic and the state register.
// ----------------------------------------------------------------------------
module gtp_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               last,
	input  logic [7:0]         char_in,
	output gtp_pkg::scan_t     nxt
);

	gtp_pkg::scan_t st_q;
	gtp_pkg::scan_t st_rst;

	always_comb begin
		st_rst = '0;
		st_rst.skipping = 1'b1;
		st_rst.error_code = gtp_pkg::ST_OK;
	end

	always_comb begin
		logic [gtp_pkg::POS_W-1:0] p;
		logic [3:0] d;
		logic [2:0] k;
		logic [4:0] h;
		logic [gtp_pkg::POS_W-1:0] rel;
		p = st_q.position;
		d = char_in[3:0];
		rel = p - 5'd6;
		k = rel[3:1];
		h = gtp_pkg::hex_val(char_in);
		nxt = st_q;
		if (p < gtp_pkg::DONE_POS &&
		    !(st_q.skipping && (char_in == gtp_pkg::CH_SPACE || char_in == gtp_pkg::CH_TAB))) begin
			nxt.skipping = 1'b0;
			if (char_in == gtp_pkg::CH_NUL) begin
				if (st_q.error_code == gtp_pkg::ST_OK) begin
					if (p < 5'd2) begin
						nxt.error_code = gtp_pkg::ST_NO_FORMAT;
					end else if (p < gtp_pkg::PCHK2) begin
						nxt.error_code = gtp_pkg::ST_FEW_FIELDS;
					end
				end
				nxt.position = gtp_pkg::DONE_POS;
			end else begin
				nxt.position = p + 5'd1;
				if (p < gtp_pkg::SUM_LEN) begin
					nxt.running_sum = st_q.running_sum + char_in;
				end
				if (p == 5'd1) begin
					if ((st_q.running_sum != gtp_pkg::CH_T || char_in != gtp_pkg::CH_2) &&
					    st_q.error_code == gtp_pkg::ST_OK) begin
						nxt.error_code = gtp_pkg::ST_NOT_T2;
					end
				end else if (p >= 5'd2 && p <= 5'd15) begin
					if (char_in < gtp_pkg::CH_0 || char_in > gtp_pkg::CH_9) begin
						if (st_q.error_code == gtp_pkg::ST_OK) begin
							nxt.error_code = gtp_pkg::ST_FEW_FIELDS;
						end
						nxt.position = gtp_pkg::DONE_POS;
					end else if (p <= 5'd5) begin
						nxt.year_acc = (st_q.year_acc << 3) + (st_q.year_acc << 1) + {10'd0, d};
					end else begin
						for (int i = 0; i < gtp_pkg::NUM_ACC; i++) begin
							if (k == 3'(i)) begin
								nxt.acc[i] = (st_q.acc[i] << 3) + (st_q.acc[i] << 1) + {3'd0, d};
							end
						end
					end
				end else if (p >= 5'd16 && p <= 5'd20) begin
					for (int i = 0; i < gtp_pkg::NUM_FLAG; i++) begin
						if (p == 5'(16 + i)) begin
							nxt.flags[i] = char_in;
						end
					end
				end else if (p == gtp_pkg::SUM_LEN) begin
					if (!h[4]) begin
						if (st_q.error_code == gtp_pkg::ST_OK) begin
							nxt.error_code = gtp_pkg::ST_FEW_FIELDS;
						end
						nxt.position = gtp_pkg::DONE_POS;
					end else begin
						nxt.expected_sum = {4'd0, h[3:0]};
					end
				end else if (p == gtp_pkg::PCHK2) begin
					if (h[4]) begin
						nxt.expected_sum = {st_q.expected_sum[3:0], h[3:0]};
					end
					nxt.position = gtp_pkg::DONE_POS;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= st_rst;
		end else if (step) begin
			st_q <= last ? st_rst : nxt;
		end
	end

endmodule

### rtl/core/gtp_eval.sv
// ----------------------------------------------------------------------------
// gtp_eval
// Final checks of a finished line and decoding of the leap state.
// ----------------------------------------------------------------------------
module gtp_eval (
	input  gtp_pkg::scan_t   st,
	output gtp_pkg::result_t res
);

	always_comb begin
		gtp_pkg::status_t s;
		gtp_pkg::leap_t lp;
		logic leap_month;
		s = st.error_code;
		lp = gtp_pkg::LEAP_NONE;
		leap_month = (st.acc[0] == gtp_pkg::MONTH_JUN) || (st.acc[0] == gtp_pkg::MONTH_DEC);
		if (s == gtp_pkg::ST_OK && st.position < 5'd2) begin
			s = gtp_pkg::ST_NO_FORMAT;
		end
		if (s == gtp_pkg::ST_OK && st.position < gtp_pkg::PCHK2) begin
			s = gtp_pkg::ST_FEW_FIELDS;
		end
		if (s == gtp_pkg::ST_OK && st.running_sum != st.expected_sum) begin
			s = gtp_pkg::ST_CHECKSUM;
		end
		if (s == gtp_pkg::ST_OK && st.flags[0] > gtp_pkg::CH_4) begin
			s = gtp_pkg::ST_QUALITY;
		end
		if (s == gtp_pkg::ST_OK) begin
			if (st.flags[4] != gtp_pkg::CH_0) begin
				lp = gtp_pkg::LEAP_NOSYNC;
			end else if (st.flags[2] == gtp_pkg::CH_0) begin
				lp = gtp_pkg::LEAP_NONE;
			end else if (st.flags[2] == gtp_pkg::CH_PLUS) begin
				lp = leap_month ? gtp_pkg::LEAP_ADD : gtp_pkg::LEAP_NONE;
			end else if (st.flags[2] == gtp_pkg::CH_MINUS) begin
				lp = leap_month ? gtp_pkg::LEAP_DEL : gtp_pkg::LEAP_NONE;
			end else begin
				s = gtp_pkg::ST_BAD_LEAP;
			end
		end
		res = '0;
		res.status = s;
		if (s == gtp_pkg::ST_OK) begin
			res.year = st.year_acc;
			res.month = st.acc[0];
			res.day = st.acc[1];
			res.hour = st.acc[2];
			res.minute = st.acc[3];
			res.second = st.acc[4];
			res.time_quality = st.flags[0];
			res.freq_quality = st.flags[1];
			res.leap_state = lp;
			res.service_request = st.flags[3];
		end
	end

endmodule

### rtl/core/gps_t2_timecode_parser.sv
// ----------------------------------------------------------------------------
// gps_t2_timecode_parser
// Byte-serial parser of a format 2 timecode line with one result per line.
//
//   Channel  Dir  tdata / tuser                          Marks
//   s_axis   in   tdata: char_in[7:0]                    tlast = line_end
//   m_axis   out  tdata: decoded fields, tuser: status   one per line
//
// One byte is accepted per cycle while the input register is not stalled.
// A byte is held in an input register and then scanned into the scanner
// state, and a final byte loads the line result into the output register.
// Only a final byte waits for a free output register, so a stalled result
// holds back the input only when the next line ends. Reset clears the
// scanner to the start of a line and empties both registers.
// ----------------------------------------------------------------------------
module gps_t2_timecode_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,   // char_in[7:0]
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// year[13:0], month[20:14], day[27:21], hour[34:28], minute[41:35],
	// second[48:42], time_quality[56:49], freq_quality[64:57],
	// leap_state[66:65], service_request[74:67], zero fill [79:75]
	output logic [gtp_pkg::TDATA_W-1:0]   m_axis_tdata,
	output logic [2:0]                    m_axis_tuser    // status[2:0]
);

	logic valid_s1;
	logic [7:0] char_s1;
	logic last_s1;
	logic advance;
	gtp_pkg::scan_t nxt;
	gtp_pkg::result_t res;
	gtp_pkg::result_t res_q;
	logic out_valid_q;

	assign advance = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	gtp_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.last    (last_s1),
		.char_in (char_s1),
		.nxt     (nxt)
	);

	gtp_eval u_eval (
		.st  (nxt),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = res_q.status;
	assign m_axis_tdata = {5'd0, res_q.service_request, res_q.leap_state,
	                       res_q.freq_quality, res_q.time_quality, res_q.second,
	                       res_q.minute, res_q.hour, res_q.day, res_q.month,
	                       res_q.year};

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != gtp_pkg::ST_OK |-> m_axis_tdata == '0)
		else $error("failed line result carries nonzero fields");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= gtp_pkg::ST_BAD_LEAP)
		else $error("result status out of range");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && last_s1) && m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
		else $error("result appeared without a final byte");

	a_last_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("final byte taken while result still pending");

endmodule

### tb/sv/gps_t2_timecode_parser_checker.sv
// ----------------------------------------------------------------------------
// gps_t2_timecode_parser_checker
// Watches both stream channels of the timecode line parser. Every accepted
// input transaction is run through a byte-level model of the line scanner;
// the final byte of a line queues the decoded result that the parser must
// produce. Every output transaction is compared field by field with the
// oldest queued result, and mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gps_t2_timecode_parser_checker
	import gtp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	input  logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,
	input  logic               s_axis_tlast,
	input  logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	input  logic [TDATA_W-1:0] m_axis_tdata,
	input  logic [2:0]         m_axis_tuser,
	output int                 fail_count,
	output int                 outstanding
);

	localparam int FIRST_DIGIT = 2;
	localparam int YEAR_END = 5;
	localparam int MONTH_START = 6;
	localparam int LAST_DIGIT = 15;
	localparam int FIRST_FLAG = 16;
	localparam int LAST_FLAG = 20;

	localparam logic [7:0] HEX_LO_A = 8'h61;
	localparam logic [7:0] HEX_LO_F = 8'h66;
	localparam logic [7:0] HEX_UP_A = 8'h41;
	localparam logic [7:0] HEX_UP_F = 8'h46;

	logic [POS_W-1:0] line_pos;
	logic             blank_skip;
	logic [13:0]      year_sum;
	logic [6:0]       pair_acc [NUM_ACC];
	logic [7:0]       flag_byte [NUM_FLAG];
	logic [7:0]       char_sum;
	logic [7:0]       check_sum;
	status_t          line_err;

	result_t line_results [$];

	function automatic int hex_value(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) return c - CH_0;
		if (c >= HEX_LO_A && c <= HEX_LO_F) return c - HEX_LO_A + 10;
		if (c >= HEX_UP_A && c <= HEX_UP_F) return c - HEX_UP_A + 10;
		return -1;
	endfunction

	task automatic clear_line();
		line_pos = '0;
		blank_skip = 1'b1;
		year_sum = '0;
		for (int i = 0; i < NUM_ACC; i++) pair_acc[i] = '0;
		for (int i = 0; i < NUM_FLAG; i++) flag_byte[i] = '0;
		char_sum = '0;
		check_sum = '0;
		line_err = ST_OK;
	endtask

	task automatic flag_error(input status_t e);
		if (line_err == ST_OK) line_err = e;
	endtask

	task automatic scan_char(input logic [7:0] c);
		int hv;
		int k;
		if (line_pos >= DONE_POS) return;
		if (blank_skip && (c == CH_SPACE || c == CH_TAB)) return;
		blank_skip = 1'b0;
		if (c == CH_NUL) begin
			if (line_pos < 2) flag_error(ST_NO_FORMAT);
			else if (line_pos < PCHK2) flag_error(ST_FEW_FIELDS);
			line_pos = DONE_POS;
			return;
		end
		// Before the second byte is added, the sum holds the first byte alone.
		if (line_pos == 1 && (char_sum != CH_T || c != CH_2)) flag_error(ST_NOT_T2);
		if (line_pos < SUM_LEN) char_sum = char_sum + c;
		hv = hex_value(c);
		if (line_pos >= FIRST_DIGIT && line_pos <= LAST_DIGIT) begin
			if (c < CH_0 || c > CH_9) begin
				flag_error(ST_FEW_FIELDS);
				line_pos = DONE_POS;
				return;
			end
			if (line_pos <= YEAR_END) begin
				year_sum = year_sum * 10 + (c - CH_0);
			end else begin
				k = (line_pos - MONTH_START) >> 1;
				pair_acc[k] = pair_acc[k] * 10 + (c - CH_0);
			end
		end else if (line_pos >= FIRST_FLAG && line_pos <= LAST_FLAG) begin
			flag_byte[line_pos - FIRST_FLAG] = c;
		end else if (line_pos == SUM_LEN) begin
			if (hv < 0) begin
				flag_error(ST_FEW_FIELDS);
				line_pos = DONE_POS;
				return;
			end
			check_sum = 8'(hv);
		end else if (line_pos == PCHK2) begin
			if (hv >= 0) check_sum = {check_sum[3:0], 4'(hv)};
			line_pos = DONE_POS;
			return;
		end
		line_pos = line_pos + 1'b1;
	endtask

	function automatic result_t close_line();
		result_t r;
		status_t st;
		leap_t   lp;
		r = '0;
		lp = LEAP_NONE;
		st = line_err;
		if (st == ST_OK && line_pos < 2) st = ST_NO_FORMAT;
		if (st == ST_OK && line_pos < PCHK2) st = ST_FEW_FIELDS;
		if (st == ST_OK && char_sum != check_sum) st = ST_CHECKSUM;
		if (st == ST_OK && flag_byte[0] > CH_4) st = ST_QUALITY;
		if (st == ST_OK) begin
			if (flag_byte[4] != CH_0) begin
				lp = LEAP_NOSYNC;
			end else if (flag_byte[2] == CH_0) begin
				lp = LEAP_NONE;
			end else if (flag_byte[2] == CH_PLUS) begin
				lp = (pair_acc[0] == MONTH_JUN || pair_acc[0] == MONTH_DEC) ? LEAP_ADD : LEAP_NONE;
			end else if (flag_byte[2] == CH_MINUS) begin
				lp = (pair_acc[0] == MONTH_JUN || pair_acc[0] == MONTH_DEC) ? LEAP_DEL : LEAP_NONE;
			end else begin
				st = ST_BAD_LEAP;
			end
		end
		r.status = st;
		if (st == ST_OK) begin
			r.year = year_sum;
			r.month = pair_acc[0];
			r.day = pair_acc[1];
			r.hour = pair_acc[2];
			r.minute = pair_acc[3];
			r.second = pair_acc[4];
			r.time_quality = flag_byte[0];
			r.freq_quality = flag_byte[1];
			r.leap_state = lp;
			r.service_request = flag_byte[3];
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v,
		input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			clear_line();
			line_results.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (line_results.size() == 0) begin
					$error("result transaction with none pending, status %0d", m_axis_tuser);
					fail_count++;
				end else begin
					want = line_results.pop_front();
					outstanding--;
					check_field("status", want.status, m_axis_tuser);
					check_field("year", want.year, m_axis_tdata[13:0]);
					check_field("month", want.month, m_axis_tdata[20:14]);
					check_field("day", want.day, m_axis_tdata[27:21]);
					check_field("hour", want.hour, m_axis_tdata[34:28]);
					check_field("minute", want.minute, m_axis_tdata[41:35]);
					check_field("second", want.second, m_axis_tdata[48:42]);
					check_field("time_quality", want.time_quality, m_axis_tdata[56:49]);
					check_field("freq_quality", want.freq_quality, m_axis_tdata[64:57]);
					check_field("leap_state", want.leap_state, m_axis_tdata[66:65]);
					check_field("service_request", want.service_request,
						m_axis_tdata[74:67]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				scan_char(s_axis_tdata);
				if (s_axis_tlast) begin
					line_results.push_back(close_line());
					outstanding++;
					clear_line();
				end
			end
		end
	end

endmodule

### tb/sv/gps_t2_timecode_parser_tb.sv
// ----------------------------------------------------------------------------
// gps_t2_timecode_parser_tb
// Feeds the timecode line parser with directed lines for the field extremes,
// leap decoding and every error status, then with random lines: mostly
// well-formed timecodes with random content, plus broken lines and noise.
// Both sides idle at random in two of three phases; the receiver holds off
// once for a long stretch. The checker module does all prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gps_t2_timecode_parser_tb;
	import gtp_pkg::*;

	typedef enum int {
		FL_NONE,
		FL_BAD_SUM,
		FL_NOT_T2,
		FL_NON_DIGIT,
		FL_EARLY_NUL,
		FL_SHORT,
		FL_BAD_QUALITY,
		FL_BAD_LEAP,
		FL_ONE_HEX,
		FL_BAD_HEX,
		FL_NOISE,
		FL_BLANK_ONLY
	} line_flaw_t;

	localparam int FILL_RANDOM = 0;
	localparam int FILL_ZERO = 1;
	localparam int FILL_NINE = 2;
	localparam int ANY = -1;
	localparam int ITEM_GOAL = 1800;
	localparam int HOLD_START = 400;
	localparam int HOLD_LEN = 300;
	localparam logic [7:0] HEX_UP_A = 8'h41;
	localparam logic [7:0] HEX_LO_A = 8'h61;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [7:0] CH_1 = 8'h31;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = '0;
	logic               s_axis_tlast = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic [2:0]         m_axis_tuser;

	int fail_count;
	int outstanding;
	int tx_idle_pct = 33;
	int rx_idle_pct = 47;
	int bytes_sent = 0;

	logic [7:0] line_buf [$];

	gps_t2_timecode_parser u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	gps_t2_timecode_parser_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : receiver
		int cyc;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	function automatic logic [7:0] digit_char(input int unsigned v);
		return CH_0 + 8'(v);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
		if (v < 10) return CH_0 + v;
		return (lower ? HEX_LO_A : HEX_UP_A) + v - 8'd10;
	endfunction

	function automatic bit is_hex(input logic [7:0] c);
		return (c >= CH_0 && c <= CH_9) || (c >= HEX_UP_A && c < HEX_UP_A + 6)
			|| (c >= HEX_LO_A && c < HEX_LO_A + 6);
	endfunction

	function automatic logic [7:0] printable();
		return 8'($urandom_range(8'h21, 8'h7e));
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_line(input line_flaw_t flaw, input int fill, input int mon,
		input logic [7:0] tq, input logic [7:0] leap_ch, input logic [7:0] sync_ch,
		input int cut);
		logic [7:0] body [$];
		logic [7:0] sum;
		logic [7:0] c;
		int n;
		int k;
		body = {};
		line_buf = {};
		n = (flaw == FL_BLANK_ONLY) ? $urandom_range(1, 4) : $urandom_range(3);
		if (flaw == FL_NOISE) begin
			repeat ($urandom_range(1, 30)) body.push_back(8'($urandom_range(255)));
		end else if (flaw != FL_BLANK_ONLY) begin
			body.push_back(CH_T);
			body.push_back(CH_2);
			for (int i = 0; i < 14; i++) begin
				k = (fill == FILL_ZERO) ? 0 : (fill == FILL_NINE) ? 9 : $urandom_range(9);
				body.push_back(digit_char(k));
			end
			if (mon >= 0) begin
				body[6] = digit_char(mon / 10);
				body[7] = digit_char(mon % 10);
			end
			body.push_back(tq);
			body.push_back(printable());
			body.push_back(leap_ch);
			body.push_back(printable());
			body.push_back(sync_ch);
			case (flaw)
				FL_NOT_T2: begin
					k = $urandom_range(1);
					body[k] = body[k] ^ 8'($urandom_range(1, 255));
				end
				FL_NON_DIGIT: begin
					do c = 8'($urandom_range(255)); while (c >= CH_0 && c <= CH_9);
					body[$urandom_range(2, 15)] = c;
				end
				FL_BAD_QUALITY: body[16] = 8'($urandom_range(8'h35, 8'hff));
				FL_BAD_LEAP: begin
					do c = 8'($urandom_range(255));
					while (c == CH_0 || c == CH_PLUS || c == CH_MINUS);
					body[18] = c;
					body[20] = CH_0;
				end
				default: ;
			endcase
			sum = '0;
			for (int i = 0; i < 21; i++) sum = sum + body[i];
			if (flaw == FL_ONE_HEX) begin
				// Adjust the service request byte so that one hex digit can match.
				k = $urandom_range(15);
				body[19] = body[19] + 8'(k) - sum;
				body.push_back(hex_char(4'(k), $urandom_range(1)));
				if ($urandom_range(1)) begin
					do c = printable(); while (is_hex(c));
					body.push_back(c);
				end
			end else if (flaw == FL_BAD_HEX) begin
				do c = 8'($urandom_range(255)); while (is_hex(c));
				body.push_back(c);
				body.push_back(hex_char(4'($urandom_range(15)), $urandom_range(1)));
			end else begin
				if (flaw == FL_BAD_SUM) sum = sum + 8'($urandom_range(1, 255));
				body.push_back(hex_char(sum[7:4], $urandom_range(1)));
				body.push_back(hex_char(sum[3:0], $urandom_range(1)));
			end
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(255)));
			end
			if (flaw == FL_SHORT) begin
				k = (cut >= 0) ? cut : $urandom_range(1, 21);
				while (body.size() > k) body.pop_back();
			end
			if (flaw == FL_EARLY_NUL) begin
				k = (cut >= 0) ? cut : $urandom_range(22);
				while (body.size() > k) body.pop_back();
				body.push_back(CH_NUL);
				repeat ($urandom_range(2)) body.push_back(8'($urandom_range(255)));
			end
		end
		repeat (n) line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
		foreach (body[i]) line_buf.push_back(body[i]);
		foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
	endtask

	task automatic random_line();
		line_flaw_t flaw;
		int r;
		int mon;
		logic [7:0] leap_ch;
		logic [7:0] sync_ch;
		r = $urandom_range(99);
		if (r < 55) flaw = FL_NONE;
		else if (r < 60) flaw = FL_BAD_SUM;
		else if (r < 64) flaw = FL_NOT_T2;
		else if (r < 68) flaw = FL_NON_DIGIT;
		else if (r < 72) flaw = FL_EARLY_NUL;
		else if (r < 76) flaw = FL_SHORT;
		else if (r < 80) flaw = FL_BAD_QUALITY;
		else if (r < 84) flaw = FL_BAD_LEAP;
		else if (r < 89) flaw = FL_ONE_HEX;
		else if (r < 92) flaw = FL_BAD_HEX;
		else if (r < 97) flaw = FL_NOISE;
		else flaw = FL_BLANK_ONLY;
		mon = ($urandom_range(2) == 0) ? ($urandom_range(1) ? 6 : 12) : $urandom_range(99);
		case ($urandom_range(2))
			0: leap_ch = CH_0;
			1: leap_ch = CH_PLUS;
			default: leap_ch = CH_MINUS;
		endcase
		sync_ch = ($urandom_range(5) == 0) ? 8'($urandom_range(1, 255)) : CH_0;
		send_line(flaw, FILL_RANDOM, mon, CH_0 + 8'($urandom_range(4)), leap_ch, sync_ch,
			ANY);
	endtask

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		send_line(FL_NONE, FILL_RANDOM, 6, CH_0, CH_PLUS, CH_0, ANY);
		send_line(FL_NONE, FILL_RANDOM, 12, CH_1, CH_MINUS, CH_0, ANY);
		send_line(FL_NONE, FILL_RANDOM, 7, CH_2, CH_PLUS, CH_0, ANY);
		send_line(FL_NONE, FILL_ZERO, ANY, CH_4, CH_0, CH_0, ANY);
		send_line(FL_NONE, FILL_NINE, ANY, CH_2, CH_MINUS, CH_0, ANY);
		send_line(FL_NONE, FILL_RANDOM, ANY, 8'hff, CH_0, CH_0, ANY);
		send_line(FL_NONE, FILL_RANDOM, 6, CH_0, CH_X, CH_1, ANY);
		send_line(FL_BAD_LEAP, FILL_RANDOM, ANY, CH_0, CH_0, CH_0, ANY);
		send_line(FL_BAD_QUALITY, FILL_RANDOM, ANY, CH_0, CH_0, CH_0, ANY);
		send_line(FL_BAD_SUM, FILL_RANDOM, ANY, CH_0, CH_0, CH_0, ANY);
		send_line(FL_NOT_T2, FILL_RANDOM, ANY, CH_0, CH_0, CH_0, ANY);
		send_line(FL_NON_DIGIT, FILL_RANDOM, ANY, CH_0, CH_0, CH_0, ANY);
		send_line(FL_BAD_HEX, FILL_RANDOM, ANY, CH_0, CH_0, CH_0, ANY);
		send_line(FL_ONE_HEX, FILL_RANDOM, ANY, CH_0, CH_0, CH_0, ANY);
		send_line(FL_SHORT, FILL_RANDOM, ANY, CH_0, CH_0, CH_0, 1);
		send_line(FL_SHORT, FILL_RANDOM, ANY, CH_0, CH_0, CH_0, 15);
		send_line(FL_EARLY_NUL, FILL_RANDOM, ANY, CH_0, CH_0, CH_0, 0);
		send_line(FL_EARLY_NUL, FILL_RANDOM, ANY, CH_0, CH_0, CH_0, 10);
		send_line(FL_EARLY_NUL, FILL_RANDOM, ANY, CH_0, CH_0, CH_0, 22);
		send_line(FL_BLANK_ONLY, FILL_RANDOM, ANY, CH_0, CH_0, CH_0, ANY);
		send_line(FL_NOISE, FILL_RANDOM, ANY, CH_0, CH_0, CH_0, ANY);

		while (bytes_sent < ITEM_GOAL) begin
			if (bytes_sent < ITEM_GOAL / 3) begin
				tx_idle_pct = 33;
				rx_idle_pct = 47;
			end else if (bytes_sent < 2 * ITEM_GOAL / 3) begin
				tx_idle_pct = 47;
				rx_idle_pct = 33;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			random_line();
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
